// File: src/script_lexer_token_scanner_top_defines.svh
// ----------------------------------------------------------------------------
// script lexer token scanner assertion macros
// concurrent checks clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LEXER_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SCRIPT_LEXER_TOKEN_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge
`define SLS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sls check failed");
// antecedent implies consequent in the next cycle
`define SLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sls check failed");
`else
`define SLS_ASSERT(lbl, cond)
`define SLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg
// shared beat types, token codes and keyword trie for the token scanner
// ----------------------------------------------------------------------------
package sls_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_kind;
        logic [15:0] lexeme_start;
        logic [15:0] lexeme_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } token_beat_t;

    // most tokens one source byte can produce
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;

    // tokens produced by one scanned byte
    typedef struct packed {
        logic [2:0]                         count;
        token_beat_t [MAX_RESULTS-1:0]      items;
    } scan_burst_t;

    // scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_SLASH   = 4'd1;
    localparam logic [3:0] M_COMMENT = 4'd2;
    localparam logic [3:0] M_OP      = 4'd3;
    localparam logic [3:0] M_STRING  = 4'd4;
    localparam logic [3:0] M_INT     = 4'd5;
    localparam logic [3:0] M_DOT     = 4'd6;
    localparam logic [3:0] M_FRAC    = 4'd7;
    localparam logic [3:0] M_IDENT   = 4'd8;

    // token kinds
    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_COMMA  = 6'd4;
    localparam logic [5:0] K_DOT    = 6'd5;
    localparam logic [5:0] K_MINUS  = 6'd6;
    localparam logic [5:0] K_PLUS   = 6'd7;
    localparam logic [5:0] K_SEMI   = 6'd8;
    localparam logic [5:0] K_SLASH  = 6'd9;
    localparam logic [5:0] K_STAR   = 6'd10;
    localparam logic [5:0] K_BANG   = 6'd11;
    localparam logic [5:0] K_EQUAL  = 6'd13;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_LESS   = 6'd17;
    localparam logic [5:0] K_IDENT  = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_NUMBER = 6'd21;
    localparam logic [5:0] K_KEY0   = 6'd22;
    localparam logic [5:0] K_ERROR  = 6'd38;
    localparam logic [5:0] K_EOF    = 6'd39;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    // trie nodes are offsets into the keyword text
    localparam logic [5:0] NODE_ROOT = 6'd62;
    localparam logic [5:0] NODE_DEAD = 6'd63;
    localparam logic [62*8-1:0] KW_TEXT =
        "andclasselsefalseforfunifnilorprintreturnsuperthistruevarwhile";

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_TAB = 8'h09;

    function automatic logic [7:0] kw_char(input logic [5:0] idx);
        int i;
        i = 61 - int'(idx);
        if (i < 0)
            return 8'd0;
        return KW_TEXT[i*8 +: 8];
    endfunction

    // token kind of an identifier that ends at this node
    function automatic logic [5:0] kw_kind(input logic [5:0] node);
        logic [5:0] k;
        case (node)
            6'd2:    k = K_KEY0 + 6'd0;
            6'd7:    k = K_KEY0 + 6'd1;
            6'd11:   k = K_KEY0 + 6'd2;
            6'd16:   k = K_KEY0 + 6'd3;
            6'd19:   k = K_KEY0 + 6'd4;
            6'd22:   k = K_KEY0 + 6'd5;
            6'd24:   k = K_KEY0 + 6'd6;
            6'd27:   k = K_KEY0 + 6'd7;
            6'd29:   k = K_KEY0 + 6'd8;
            6'd34:   k = K_KEY0 + 6'd9;
            6'd40:   k = K_KEY0 + 6'd10;
            6'd45:   k = K_KEY0 + 6'd11;
            6'd49:   k = K_KEY0 + 6'd12;
            6'd53:   k = K_KEY0 + 6'd13;
            6'd56:   k = K_KEY0 + 6'd14;
            6'd61:   k = K_KEY0 + 6'd15;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    // one step of the keyword trie
    function automatic logic [5:0] trie_step(input logic [5:0] node, input logic [7:0] c);
        logic [5:0] nxt;
        nxt = NODE_DEAD;
        if (node == NODE_ROOT) begin
            case (c)
                "a":     nxt = 6'd0;
                "c":     nxt = 6'd3;
                "e":     nxt = 6'd8;
                "f":     nxt = 6'd12;
                "i":     nxt = 6'd23;
                "n":     nxt = 6'd25;
                "o":     nxt = 6'd28;
                "p":     nxt = 6'd30;
                "r":     nxt = 6'd35;
                "s":     nxt = 6'd41;
                "t":     nxt = 6'd46;
                "v":     nxt = 6'd54;
                "w":     nxt = 6'd57;
                default: nxt = NODE_DEAD;
            endcase
        end else if (node == 6'd12) begin
            // "f" branches to false, for, fun
            case (c)
                "a":     nxt = 6'd13;
                "o":     nxt = 6'd18;
                "u":     nxt = 6'd21;
                default: nxt = NODE_DEAD;
            endcase
        end else if (node == 6'd46) begin
            // "t" branches to this, true
            case (c)
                "h":     nxt = 6'd47;
                "r":     nxt = 6'd51;
                default: nxt = NODE_DEAD;
            endcase
        end else if (node < NODE_ROOT && kw_kind(node) == K_IDENT) begin
            if (kw_char(node + 6'd1) == c)
                nxt = node + 6'd1;
        end
        return nxt;
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] ch);
        logic [5:0] k;
        case (ch)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            ">":     k = K_GREATER;
            default: k = K_LESS;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [15:0] span(input logic [15:0] a, input logic [15:0] b);
        return (b > a) ? (b - a) : 16'd0;
    endfunction

    function automatic token_beat_t make_tok(input logic [5:0] kind, input logic [1:0] err,
                                             input logic [15:0] start, input logic [15:0] len,
                                             input logic [15:0] line);
        token_beat_t t;
        t.token_kind    = kind;
        t.error_kind    = err;
        t.lexeme_start  = start;
        t.lexeme_length = len;
        t.line_number   = line;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

endpackage

// File: src/sls_scan.sv
// ----------------------------------------------------------------------------
// sls_scan
// scanner state and the combinational update that turns one byte into tokens
// ----------------------------------------------------------------------------
module sls_scan
    import sls_pkg::*;
#(
    parameter logic [15:0] POS_CAP = 16'hffff
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  byte_beat_t  beat,
    output scan_burst_t burst
);

    logic [3:0]  mode_reg, mode_next;
    logic [15:0] tstart_reg, tstart_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] line_reg, line_next;
    logic [5:0]  node_reg, node_next;
    logic [7:0]  pend_reg, pend_next;

    // byte update: continue open token, else close and dispatch, then flush on final
    always_comb
    begin
        logic [7:0]  c;
        logic        used;
        logic        do_close;
        logic [2:0]  n;
        logic [15:0] p;
        logic [15:0] dot;
        logic [15:0] posn;
        c         = beat.char_byte;
        used      = 1'b0;
        n         = 3'd0;
        do_close  = 1'b0;
        p         = 16'd0;
        dot       = 16'd0;
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        line_next   = line_reg;
        node_next   = node_reg;
        pend_next   = pend_reg;
        posn      = (pos_reg < POS_CAP) ? pos_reg + 16'd1 : POS_CAP;
        pos_next  = posn;
        burst.items = '0;

        // open token takes the byte
        case (mode_reg)
            M_SLASH:
            begin
                if (c == "/")
                begin
                    mode_next = M_COMMENT;
                    used      = 1'b1;
                end
            end
            M_OP:
            begin
                if (c == "=")
                begin
                    burst.items[0] = make_tok(op_single(pend_reg) + 6'd1, E_NONE, tstart_reg,
                                              span(tstart_reg, posn), line_next);
                    n         = 3'd1;
                    mode_next = M_IDLE;
                    pend_next = 8'd0;
                    used      = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (c == CH_LF)
                begin
                    if (line_next != 16'hffff)
                        line_next = line_next + 16'd1;
                    mode_next = M_IDLE;
                end
                used = 1'b1;
            end
            M_STRING:
            begin
                if (c == "\"")
                begin
                    burst.items[0] = make_tok(K_STRING, E_NONE, tstart_reg,
                                              span(tstart_reg, posn), line_next);
                    n         = 3'd1;
                    mode_next = M_IDLE;
                end else if (c == CH_LF)
                begin
                    if (line_next != 16'hffff)
                        line_next = line_next + 16'd1;
                end
                used = 1'b1;
            end
            M_INT:
            begin
                if (is_digit(c))
                    used = 1'b1;
                else if (c == ".")
                begin
                    mode_next = M_DOT;
                    pend_next = (pos_reg == POS_CAP) ? 8'd1 : 8'd0;
                    used      = 1'b1;
                end
            end
            M_DOT:
            begin
                if (is_digit(c))
                begin
                    mode_next = M_FRAC;
                    pend_next = 8'd0;
                    used      = 1'b1;
                end
            end
            M_FRAC:
            begin
                if (is_digit(c))
                    used = 1'b1;
            end
            M_IDENT:
            begin
                if (is_alpha(c) || is_digit(c))
                begin
                    node_next = trie_step(node_reg, c);
                    used      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // pass 0 closes before dispatch, pass 1 flushes at the final byte
        for (int pass = 0; pass < 2; pass++)
        begin
            do_close = (pass == 0) ? !used : beat.final_byte;
            p        = (pass == 0) ? pos_reg : posn;
            if (do_close)
            begin
                case (mode_next)
                    M_SLASH:
                    begin
                        burst.items[n[1:0]] = make_tok(K_SLASH, E_NONE, tstart_next, 16'd1,
                                                       line_next);
                        n = n + 3'd1;
                    end
                    M_OP:
                    begin
                        burst.items[n[1:0]] = make_tok(op_single(pend_next), E_NONE,
                                                       tstart_next, 16'd1, line_next);
                        n = n + 3'd1;
                    end
                    M_INT, M_FRAC:
                    begin
                        burst.items[n[1:0]] = make_tok(K_NUMBER, E_NONE, tstart_next,
                                                       span(tstart_next, p), line_next);
                        n = n + 3'd1;
                    end
                    M_DOT:
                    begin
                        dot = (pend_next != 8'd0) ? POS_CAP :
                              ((p > 16'd0) ? p - 16'd1 : 16'd0);
                        burst.items[n[1:0]] = make_tok(K_NUMBER, E_NONE, tstart_next,
                                                       span(tstart_next, dot), line_next);
                        n = n + 3'd1;
                        burst.items[n[1:0]] = make_tok(K_DOT, E_NONE, dot, 16'd1, line_next);
                        n = n + 3'd1;
                    end
                    M_IDENT:
                    begin
                        burst.items[n[1:0]] = make_tok(kw_kind(node_next), E_NONE,
                                                       tstart_next, span(tstart_next, p),
                                                       line_next);
                        n = n + 3'd1;
                    end
                    M_STRING:
                    begin
                        burst.items[n[1:0]] = make_tok(K_ERROR, E_UNTERM, tstart_next,
                                                       span(tstart_next, p), line_next);
                        n = n + 3'd1;
                    end
                    default:
                    begin
                    end
                endcase
                mode_next = M_IDLE;
                pend_next = 8'd0;
            end

            // start a new token
            if (pass == 0 && !used)
            begin
                tstart_next = pos_reg;
                case (c)
                    " ", CH_CR, CH_TAB:
                    begin
                    end
                    CH_LF:
                    begin
                        if (line_next != 16'hffff)
                            line_next = line_next + 16'd1;
                    end
                    "(", ")", "{", "}", ",", ".", "-", "+", ";", "*":
                    begin
                        case (c)
                            "(":     burst.items[n[1:0]].token_kind = K_LPAREN;
                            ")":     burst.items[n[1:0]].token_kind = K_RPAREN;
                            "{":     burst.items[n[1:0]].token_kind = K_LBRACE;
                            "}":     burst.items[n[1:0]].token_kind = K_RBRACE;
                            ",":     burst.items[n[1:0]].token_kind = K_COMMA;
                            ".":     burst.items[n[1:0]].token_kind = K_DOT;
                            "-":     burst.items[n[1:0]].token_kind = K_MINUS;
                            "+":     burst.items[n[1:0]].token_kind = K_PLUS;
                            ";":     burst.items[n[1:0]].token_kind = K_SEMI;
                            default: burst.items[n[1:0]].token_kind = K_STAR;
                        endcase
                        burst.items[n[1:0]].error_kind    = E_NONE;
                        burst.items[n[1:0]].lexeme_start  = pos_reg;
                        burst.items[n[1:0]].lexeme_length = 16'd1;
                        burst.items[n[1:0]].line_number   = line_next;
                        burst.items[n[1:0]].last_of_run   = 1'b0;
                        n = n + 3'd1;
                    end
                    "/":
                        mode_next = M_SLASH;
                    "!", "=", "<", ">":
                    begin
                        mode_next = M_OP;
                        pend_next = c;
                    end
                    "\"":
                        mode_next = M_STRING;
                    default:
                    begin
                        if (is_digit(c))
                            mode_next = M_INT;
                        else if (is_alpha(c))
                        begin
                            mode_next = M_IDENT;
                            node_next = trie_step(NODE_ROOT, c);
                        end else
                        begin
                            burst.items[n[1:0]] = make_tok(K_ERROR, E_UNEXPECTED, pos_reg,
                                                           16'd1, line_next);
                            n = n + 3'd1;
                        end
                    end
                endcase
            end

            // end of file and return to reset state
            if (pass == 1 && beat.final_byte)
            begin
                burst.items[n[1:0]] = make_tok(K_EOF, E_NONE, posn, 16'd0, line_next);
                n = n + 3'd1;
                mode_next   = M_IDLE;
                tstart_next = 16'd0;
                pos_next    = 16'd0;
                line_next   = 16'd1;
                node_next   = NODE_ROOT;
                pend_next   = 8'd0;
            end
        end

        if (n != 3'd0)
            burst.items[n[1:0] - 2'd1].last_of_run = 1'b1;
        burst.count = n;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            tstart_reg <= 16'd0;
            pos_reg    <= 16'd0;
            line_reg   <= 16'd1;
            node_reg   <= NODE_ROOT;
            pend_reg   <= 8'd0;
        end else if (go)
        begin
            mode_reg   <= mode_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            node_reg   <= node_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// File: src/sls_queue.sv
// ----------------------------------------------------------------------------
// sls_queue
// token queue: takes a burst of up to four tokens, hands out one per beat
// ----------------------------------------------------------------------------
module sls_queue
    import sls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  scan_burst_t burst,
    output logic        room,
    output logic [QUEUE_AW:0] level,
    output logic        token_valid,
    input  logic        token_stall,
    output token_beat_t token_data
);

    token_beat_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                pop;
    logic [2:0]          push_n;

    assign pop         = token_valid && !token_stall;
    assign push_n      = push ? burst.count : 3'd0;
    assign count_next  = count_reg + {1'b0, push_n} - {{QUEUE_AW{1'b0}}, pop};
    assign room        = count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - MAX_RESULTS);
    assign level       = count_reg;
    assign token_valid = count_reg != '0;
    assign token_data  = mem_reg[rd_reg];

    // storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (push && (3'(i) < burst.count))
                mem_reg[wr_reg + QUEUE_AW'(i)] <= burst.items[i];
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else
        begin
            wr_reg    <= wr_reg + push_n[QUEUE_AW-1:0];
            rd_reg    <= rd_reg + {{(QUEUE_AW-1){1'b0}}, pop};
            count_reg <= count_next;
        end
    end

endmodule

// File: src/script_lexer_token_scanner_top.sv
// ----------------------------------------------------------------------------
// script_lexer_token_scanner_top
// streaming lexer: source bytes in, tokens with offset, length and line out
// ----------------------------------------------------------------------------
// Takes one source byte per clock and returns tokens in source order; an
// accepted byte is registered, scanned once the queue has room and its zero
// to four tokens go into an eight-entry queue, so a byte enters every cycle
// while the queue has room for four more tokens. Tokens leave at one per
// cycle while token_stall is low, so the sustained rate is one byte per
// cycle when the text gives at most one token per byte on average. The byte
// flagged final flushes the open token, ends with an end-of-file token and
// restarts the scanner at offset 0, line 1.
`include "script_lexer_token_scanner_top_defines.svh"

module script_lexer_token_scanner_top
    import sls_pkg::*;
#(
    parameter int MAX_SOURCE_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  byte_beat_t  byte_data,
    output logic        token_valid,
    input  logic        token_stall,
    output token_beat_t token_data
);

    localparam int          CAP_INT = (MAX_SOURCE_BYTES - 1 > 65535) ? 65535
                                                                     : MAX_SOURCE_BYTES - 1;
    localparam logic [15:0] POS_CAP = 16'(CAP_INT);

    logic               hold_valid_reg, hold_valid_next;
    byte_beat_t         hold_beat_reg;
    logic               room;
    logic               go;
    logic [QUEUE_AW:0]  level;
    scan_burst_t        burst;

    assign go         = hold_valid_reg && room;
    assign byte_stall = hold_valid_reg && !room;

    // input beat register
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (byte_valid && !byte_stall)
            hold_valid_next = 1'b1;
        else if (go)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            hold_beat_reg <= byte_data;
    end

    sls_scan #(
        .POS_CAP (POS_CAP)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .beat  (hold_beat_reg),
        .burst (burst)
    );

    sls_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (go),
        .burst       (burst),
        .room        (room),
        .level       (level),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_data  (token_data)
    );

    // checks
    `SLS_ASSERT(a_level_bound, level <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    `SLS_ASSERT(a_final_gives_eof, !(go && hold_beat_reg.final_byte) || burst.count != 3'd0)
    `SLS_ASSERT(a_burst_bound, !go || burst.count <= 3'(MAX_RESULTS))
    `SLS_ASSERT_NEXT(a_push_visible, go && burst.count != 3'd0, token_valid)

endmodule
